### hdl/fsvtm_pkg.sv
// Package with the shared types and constants of the four-state trigger comparator.
package fsvtm_pkg;

    // Sample and table width in bits, and the number of table words.
    localparam int VALUE_BITS = 64;
    localparam int NUM_WORDS  = 4;

    // Register file layout: 64-bit registers at byte address 8*index.
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int REG_IDX_W  = 3;
    localparam int WCNT_W     = 3;
    localparam int REG_WORDS  = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_WCOUNT = 3'd1,
        REG_WORD0  = 3'd2,
        REG_WORD1  = 3'd3,
        REG_WORD2  = 3'd4,
        REG_WORD3  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_EXACT = 2'd0,
        MODE_RANGE = 2'd1,
        MODE_MASK  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        V_NO    = 2'd0,
        V_YES   = 2'd1,
        V_UNRES = 2'd2
    } t_verdict;

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic [63:0] sample_bits;
        logic [63:0] sample_unknown;
        logic        sample_valid;
        logic [1:0]  earlier_verdict;
    } t_req;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] own_verdict;
    } t_result;

endpackage

### hdl/four_state_value_trigger_match.sv
// Top level of the four-state trigger comparator with its register file.
//
// The block compares one four-state sample per request against the configured
// table and returns one result per request. A request is taken on every clock
// edge where start is high; busy is never raised, so a new request may follow
// in every cycle. Each result appears on o_result for exactly one cycle, marked
// by o_result_valid. The request passes through the request register and then
// the result register, with the comparison logic between them. The receiver
// cannot stall the block, so results must be captured when the strobe is high.
// Configuration goes through the APB port, one 64-bit register per 8-byte slot,
// and should only be changed while no request is in flight.
module four_state_value_trigger_match (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel.
    input  logic                         start,
    output logic                         busy,
    input  fsvtm_pkg::t_req              i_req,
    // Result channel.
    output logic                         o_result_valid,
    output fsvtm_pkg::t_result           o_result,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fsvtm_pkg::ADDR_W-1:0] paddr,
    input  logic [fsvtm_pkg::DATA_W-1:0] pwdata,
    output logic [fsvtm_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    // Configuration registers.
    logic [1:0]                        r_mode;
    logic [fsvtm_pkg::WCNT_W-1:0]      r_word_count;
    fsvtm_pkg::t_value                 r_table [fsvtm_pkg::NUM_WORDS];

    // Request and result pipeline registers.
    logic                              r_in_valid;
    fsvtm_pkg::t_req                   r_req;
    logic                              r_out_valid;
    fsvtm_pkg::t_result                r_result;
    fsvtm_pkg::t_result                n_result;

    logic                              cfg_write;
    logic [fsvtm_pkg::REG_IDX_W-1:0]   cfg_idx;

    // Comparison signals.
    fsvtm_pkg::t_value                 bits;
    fsvtm_pkg::t_value                 unk;
    fsvtm_pkg::t_value                 mask_u;
    fsvtm_pkg::t_value                 mask_m;
    fsvtm_pkg::t_value                 mask_any;
    fsvtm_pkg::t_value                 mask_low;
    logic                              exact_hit;
    logic                              range_hit;
    fsvtm_pkg::t_verdict               own;
    fsvtm_pkg::t_verdict               earlier;
    fsvtm_pkg::t_verdict               combined;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[fsvtm_pkg::ADDR_W-1:fsvtm_pkg::ADDR_W-fsvtm_pkg::REG_IDX_W];

    // Register writes. Indexes past the last table word are dropped, and table
    // words that have no register slot keep their reset value of zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= fsvtm_pkg::MODE_EXACT;
            r_word_count <= fsvtm_pkg::WCNT_W'(1);
            for (int k = 0; k < fsvtm_pkg::NUM_WORDS; k++) begin
                r_table[k] <= '0;
            end
        end else if (cfg_write) begin
            if (cfg_idx == fsvtm_pkg::REG_MODE) begin
                r_mode <= pwdata[1:0];
            end
            if (cfg_idx == fsvtm_pkg::REG_WCOUNT) begin
                r_word_count <= pwdata[fsvtm_pkg::WCNT_W-1:0];
            end
            for (int k = 0; k < fsvtm_pkg::NUM_WORDS; k++) begin
                if (k < fsvtm_pkg::REG_WORDS &&
                    cfg_idx == fsvtm_pkg::REG_IDX_W'(int'(fsvtm_pkg::REG_WORD0) + k)) begin
                    r_table[k] <= pwdata[fsvtm_pkg::VALUE_BITS-1:0];
                end
            end
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        if (cfg_idx == fsvtm_pkg::REG_MODE) begin
            prdata = fsvtm_pkg::DATA_W'(r_mode);
        end
        if (cfg_idx == fsvtm_pkg::REG_WCOUNT) begin
            prdata = fsvtm_pkg::DATA_W'(r_word_count);
        end
        for (int k = 0; k < fsvtm_pkg::NUM_WORDS; k++) begin
            if (k < fsvtm_pkg::REG_WORDS &&
                cfg_idx == fsvtm_pkg::REG_IDX_W'(int'(fsvtm_pkg::REG_WORD0) + k)) begin
                prdata = fsvtm_pkg::DATA_W'(r_table[k]);
            end
        end
    end

    // Request register: since busy never rises, every start is a request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    // Only the low VALUE_BITS of the sample take part in the comparison.
    assign bits = r_req.sample_bits[fsvtm_pkg::VALUE_BITS-1:0];
    assign unk  = r_req.sample_unknown[fsvtm_pkg::VALUE_BITS-1:0];

    // Mask mode: the lowest masked position that is either unknown or a known
    // mismatch decides the verdict. An unknown bit there makes it unresolved.
    assign mask_u   = r_table[1] & unk;
    assign mask_m   = r_table[1] & ~unk & (bits ^ r_table[0]);
    assign mask_any = mask_u | mask_m;
    assign mask_low = mask_any & (~mask_any + fsvtm_pkg::VALUE_BITS'(1));

    // Exact mode: a word takes part only if its index is below word_count, which
    // also caps the count at the table depth.
    always_comb begin
        exact_hit = 1'b0;
        for (int k = 0; k < fsvtm_pkg::NUM_WORDS; k++) begin
            if (k < int'(r_word_count) && r_table[k] == bits) begin
                exact_hit = 1'b1;
            end
        end
    end

    // Range mode is inclusive at both ends; a begin above the end never hits.
    assign range_hit = (r_table[0] <= bits) && (bits <= r_table[1]);

    always_comb begin
        own = fsvtm_pkg::V_NO;
        unique case (r_mode)
            fsvtm_pkg::MODE_MASK: begin
                if (mask_any == '0) begin
                    own = fsvtm_pkg::V_YES;
                end else if ((mask_low & mask_u) != '0) begin
                    own = fsvtm_pkg::V_UNRES;
                end else begin
                    own = fsvtm_pkg::V_NO;
                end
            end
            fsvtm_pkg::MODE_EXACT: begin
                if (!r_req.sample_valid || unk != '0) begin
                    own = fsvtm_pkg::V_UNRES;
                end else begin
                    own = exact_hit ? fsvtm_pkg::V_YES : fsvtm_pkg::V_NO;
                end
            end
            fsvtm_pkg::MODE_RANGE: begin
                if (!r_req.sample_valid || unk != '0) begin
                    own = fsvtm_pkg::V_UNRES;
                end else begin
                    own = range_hit ? fsvtm_pkg::V_YES : fsvtm_pkg::V_NO;
                end
            end
            default: begin
                // The spare mode code never matches.
                own = fsvtm_pkg::V_NO;
            end
        endcase
    end

    // The spare earlier-verdict code counts as unresolved.
    always_comb begin
        case (r_req.earlier_verdict)
            fsvtm_pkg::V_NO:  earlier = fsvtm_pkg::V_NO;
            fsvtm_pkg::V_YES: earlier = fsvtm_pkg::V_YES;
            default:          earlier = fsvtm_pkg::V_UNRES;
        endcase
    end

    // Three-valued AND: any no wins, then yes only if both are yes.
    always_comb begin
        if (earlier == fsvtm_pkg::V_NO || own == fsvtm_pkg::V_NO) begin
            combined = fsvtm_pkg::V_NO;
        end else if (earlier == fsvtm_pkg::V_YES && own == fsvtm_pkg::V_YES) begin
            combined = fsvtm_pkg::V_YES;
        end else begin
            combined = fsvtm_pkg::V_UNRES;
        end
        n_result.verdict     = combined;
        n_result.own_verdict = own;
    end

    // Result register and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    // Every registered request produces a result strobe in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_result_valid)
        else $error("request did not produce a result");

    // A no from this filter forces a combined no.
    a_own_no: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.own_verdict == fsvtm_pkg::V_NO)
        |-> o_result.verdict == fsvtm_pkg::V_NO)
        else $error("combined verdict not no after own no");

    // A combined yes needs this filter's yes.
    a_yes_needs_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.verdict == fsvtm_pkg::V_YES)
        |-> o_result.own_verdict == fsvtm_pkg::V_YES)
        else $error("combined yes without own yes");

    // An unresolved own verdict can never combine to yes.
    a_unres_not_yes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.own_verdict == fsvtm_pkg::V_UNRES)
        |-> o_result.verdict != fsvtm_pkg::V_YES)
        else $error("unresolved own verdict combined to yes");

endmodule

### dv/tb_four_state_value_trigger_match.sv
// Self-checking testbench for the four-state trigger comparator, with a verdict scoreboard.
class verdict_scoreboard;
    // Shadow copy of the register file, updated on every completed APB write.
    logic [1:0]                   mode_q;
    logic [fsvtm_pkg::WCNT_W-1:0] wcount_q;
    fsvtm_pkg::t_value            words [fsvtm_pkg::NUM_WORDS];
    // Verdicts predicted for accepted requests, oldest first.
    fsvtm_pkg::t_result           verdict_q [$];
    int                           errors;

    function new();
        mode_q   = fsvtm_pkg::MODE_EXACT;
        wcount_q = fsvtm_pkg::WCNT_W'(1);
        foreach (words[k]) words[k] = '0;
        errors   = 0;
    endfunction

    function void apply_write(logic [fsvtm_pkg::REG_IDX_W-1:0] idx,
                              logic [fsvtm_pkg::DATA_W-1:0] val);
        case (idx)
            fsvtm_pkg::REG_MODE:   mode_q   = val[1:0];
            fsvtm_pkg::REG_WCOUNT: wcount_q = val[fsvtm_pkg::WCNT_W-1:0];
            fsvtm_pkg::REG_WORD0:  words[0] = val[fsvtm_pkg::VALUE_BITS-1:0];
            fsvtm_pkg::REG_WORD1:  words[1] = val[fsvtm_pkg::VALUE_BITS-1:0];
            fsvtm_pkg::REG_WORD2:  words[2] = val[fsvtm_pkg::VALUE_BITS-1:0];
            fsvtm_pkg::REG_WORD3:  words[3] = val[fsvtm_pkg::VALUE_BITS-1:0];
            default: ;
        endcase
    endfunction

    function fsvtm_pkg::t_verdict own_match(fsvtm_pkg::t_req r);
        fsvtm_pkg::t_value u;
        fsvtm_pkg::t_value m;
        fsvtm_pkg::t_value diff;
        fsvtm_pkg::t_value low;
        int                n;
        case (mode_q)
            fsvtm_pkg::MODE_MASK: begin
                // The lowest masked position that is unknown or differs decides.
                u    = words[1] & r.sample_unknown;
                m    = words[1] & ~r.sample_unknown & (r.sample_bits ^ words[0]);
                diff = u | m;
                if (diff == '0) return fsvtm_pkg::V_YES;
                low = diff & (~diff + 1'b1);
                return ((low & u) != '0) ? fsvtm_pkg::V_UNRES : fsvtm_pkg::V_NO;
            end
            fsvtm_pkg::MODE_EXACT: begin
                if (!r.sample_valid || r.sample_unknown != '0) return fsvtm_pkg::V_UNRES;
                n = (wcount_q > fsvtm_pkg::NUM_WORDS) ? fsvtm_pkg::NUM_WORDS : wcount_q;
                for (int k = 0; k < n; k++)
                    if (words[k] == r.sample_bits) return fsvtm_pkg::V_YES;
                return fsvtm_pkg::V_NO;
            end
            fsvtm_pkg::MODE_RANGE: begin
                if (!r.sample_valid || r.sample_unknown != '0) return fsvtm_pkg::V_UNRES;
                return (words[0] <= r.sample_bits && r.sample_bits <= words[1]) ?
                       fsvtm_pkg::V_YES : fsvtm_pkg::V_NO;
            end
            default: return fsvtm_pkg::V_NO;
        endcase
    endfunction

    // Three-valued AND; an earlier verdict of three falls through to unresolved.
    function logic [1:0] and3(fsvtm_pkg::t_verdict a, logic [1:0] b);
        if (a == fsvtm_pkg::V_NO || b == fsvtm_pkg::V_NO) return fsvtm_pkg::V_NO;
        if (a == fsvtm_pkg::V_YES && b == fsvtm_pkg::V_YES) return fsvtm_pkg::V_YES;
        return fsvtm_pkg::V_UNRES;
    endfunction

    function void note_request(fsvtm_pkg::t_req r);
        fsvtm_pkg::t_verdict own;
        fsvtm_pkg::t_result  want;
        own              = own_match(r);
        want.own_verdict = own;
        want.verdict     = and3(own, r.earlier_verdict);
        verdict_q        = {verdict_q, want};
    endfunction

    function void check_result(fsvtm_pkg::t_result got);
        fsvtm_pkg::t_result want;
        if (verdict_q.size() == 0) begin
            errors++;
            $display("%0t: result with no request pending: verdict=%0d own_verdict=%0d",
                     $time, got.verdict, got.own_verdict);
            return;
        end
        want = verdict_q.pop_front();
        if (got.verdict !== want.verdict) begin
            errors++;
            $display("%0t: verdict mismatch: expected %0d actual %0d",
                     $time, want.verdict, got.verdict);
        end
        if (got.own_verdict !== want.own_verdict) begin
            errors++;
            $display("%0t: own_verdict mismatch: expected %0d actual %0d",
                     $time, want.own_verdict, got.own_verdict);
        end
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction
endclass

module tb_four_state_value_trigger_match;

    // Register slots past the end of the map; writes there must be ignored.
    localparam logic [fsvtm_pkg::REG_IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [fsvtm_pkg::REG_IDX_W-1:0] REG_SPARE1 = 3'd7;

    // Enough cycles for the two-stage pipeline to empty, with margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 200;

    // Every input starts at a known value at time zero.
    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start   = 1'b0;
    logic                         busy;
    fsvtm_pkg::t_req              i_req   = '0;
    logic                         o_result_valid;
    fsvtm_pkg::t_result           o_result;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [fsvtm_pkg::ADDR_W-1:0] paddr   = '0;
    logic [fsvtm_pkg::DATA_W-1:0] pwdata  = '0;
    logic [fsvtm_pkg::DATA_W-1:0] prdata;
    logic                         pready;

    verdict_scoreboard sb;

    // Percent chance that the sender inserts a gap before a request.
    int idle_pct = 11;

    four_state_value_trigger_match dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial forever #10 i_clk = ~i_clk;

    // Hard stop in case the block hangs or drops results.
    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Monitor. All stimulus is driven with nonblocking assignments at the rising
    // edge, so the values read here are the ones the block sees at this edge. A
    // request is taken when start is high and busy is low; a result is taken
    // whenever its strobe is high, since the receiver has no way to stall it.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_request(i_req);
        if (i_rst_n && o_result_valid) sb.check_result(o_result);
    end

    function automatic fsvtm_pkg::t_value rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic fsvtm_pkg::t_value one_hot();
        return fsvtm_pkg::t_value'(1) << $urandom_range(0, fsvtm_pkg::VALUE_BITS - 1);
    endfunction

    // Random table or sample value, with the extremes showing up often.
    function automatic fsvtm_pkg::t_value pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return one_hot();
            3:       return fsvtm_pkg::t_value'($urandom_range(0, 15));
            default: return rand64();
        endcase
    endfunction

    function automatic fsvtm_pkg::t_req mk(fsvtm_pkg::t_value bits, fsvtm_pkg::t_value unk,
                                           logic valid, logic [1:0] earlier);
        fsvtm_pkg::t_req r;
        r.sample_bits     = bits;
        r.sample_unknown  = unk;
        r.sample_valid    = valid;
        r.earlier_verdict = earlier;
        return r;
    endfunction

    // Present one request and hold it until the block takes it. Start stays high
    // afterward so that back-to-back requests go out on consecutive cycles.
    task automatic drive_req(fsvtm_pkg::t_req r);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            i_req.sample_bits <= rand64();
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has come back, then let
    // the pipeline settle so that a register change cannot hit a request in flight.
    task automatic drain();
        int n;
        n = 0;
        start <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (sb.pending() != 0 && n < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the data at
    // the edge where psel, penable, pwrite and pready are all high.
    task automatic apb_write(logic [fsvtm_pkg::REG_IDX_W-1:0] idx,
                             logic [fsvtm_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.apply_write(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reprogram the whole register file once the block is idle. Now and then a
    // write also goes to an unmapped slot, which must change nothing.
    task automatic set_cfg(input logic [63:0] mode_val, wcount_val, w0, w1, w2, w3);
        drain();
        apb_write(fsvtm_pkg::REG_MODE,   mode_val);
        apb_write(fsvtm_pkg::REG_WCOUNT, wcount_val);
        apb_write(fsvtm_pkg::REG_WORD0,  w0);
        apb_write(fsvtm_pkg::REG_WORD1,  w1);
        apb_write(fsvtm_pkg::REG_WORD2,  w2);
        apb_write(fsvtm_pkg::REG_WORD3,  w3);
        if ($urandom_range(0, 3) == 0)
            apb_write($urandom_range(0, 1) ? REG_SPARE0 : REG_SPARE1, rand64());
    endtask

    initial begin
        fsvtm_pkg::t_value w [fsvtm_pkg::NUM_WORDS];
        fsvtm_pkg::t_value tmp;
        fsvtm_pkg::t_value bits;
        fsvtm_pkg::t_value unk;
        logic [1:0]        mode;
        logic [63:0]       mode_val;
        logic [63:0]       wc_val;
        int                k;

        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: exact mode with one word, equal to zero.
        drive_req(mk('0, '0, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk(64'd1, '0, 1'b1, fsvtm_pkg::V_YES));
        // An invalid sample or any unknown bit leaves exact mode unresolved.
        drive_req(mk('0, '0, 1'b0, fsvtm_pkg::V_YES));
        drive_req(mk('0, 64'd1, 1'b1, fsvtm_pkg::V_YES));
        // Earlier verdict of three combines like unresolved; then the others.
        drive_req(mk('0, '0, 1'b1, 2'd3));
        drive_req(mk('0, '0, 1'b1, fsvtm_pkg::V_NO));
        drive_req(mk('0, '0, 1'b1, fsvtm_pkg::V_UNRES));

        // Exact list with all four words, extremes included.
        set_cfg(64'(fsvtm_pkg::MODE_EXACT), 64'd4, '0, '1, 64'd5, 64'h8000_0000_0000_0000);
        drive_req(mk('1, '0, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk(64'h8000_0000_0000_0000, '0, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk(64'd6, '0, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk('1, '1, 1'b1, fsvtm_pkg::V_YES));

        // A word count of zero uses no word at all.
        set_cfg(64'(fsvtm_pkg::MODE_EXACT), 64'd0, '0, '1, 64'd5, 64'd7);
        drive_req(mk('0, '0, 1'b1, fsvtm_pkg::V_YES));

        // A word count above the table size saturates, so word three still counts.
        set_cfg(64'(fsvtm_pkg::MODE_EXACT), 64'd7, 64'd1, 64'd2, 64'd3, 64'd4);
        drive_req(mk(64'd4, '0, 1'b1, fsvtm_pkg::V_YES));

        // Inclusive range, both ends and just outside them.
        set_cfg(64'(fsvtm_pkg::MODE_RANGE), 64'd1, 64'd10, 64'd20, '1, '1);
        drive_req(mk(64'd10, '0, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk(64'd20, '0, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk(64'd9, '0, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk(64'd21, '0, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk(64'd15, '0, 1'b0, fsvtm_pkg::V_YES));

        // A range whose begin lies above its end is empty.
        set_cfg(64'(fsvtm_pkg::MODE_RANGE), 64'd1, 64'd20, 64'd10, '0, '0);
        drive_req(mk(64'd15, '0, 1'b1, fsvtm_pkg::V_YES));

        // Mask mode: unknown bits outside the mask and the valid flag do not matter;
        // among masked bits the lowest unknown or differing one decides.
        set_cfg(64'(fsvtm_pkg::MODE_MASK), 64'd1, 64'hA5, 64'hFF00_0000_0000_00FF, '0, '0);
        drive_req(mk(64'hA5, 64'hFF00, 1'b0, fsvtm_pkg::V_YES));
        drive_req(mk(64'hA4, 64'h10, 1'b1, fsvtm_pkg::V_YES));
        drive_req(mk(64'h25, 64'h02, 1'b1, fsvtm_pkg::V_YES));

        // An empty mask matches anything, even a fully unknown sample.
        set_cfg(64'(fsvtm_pkg::MODE_MASK), 64'd1, '1, '0, '0, '0);
        drive_req(mk(rand64(), '1, 1'b0, fsvtm_pkg::V_YES));

        // The unused mode code never matches; unmapped slots are written too.
        set_cfg(64'd3, 64'd1, '0, '0, '0, '0);
        apb_write(REG_SPARE0, '1);
        apb_write(REG_SPARE1, '1);
        drive_req(mk('0, '0, 1'b1, fsvtm_pkg::V_YES));

        // Random phases: fresh register contents, then a burst of requests. The
        // middle phases run with no gaps at all between requests.
        for (int phase = 0; phase < 28; phase++) begin
            idle_pct = (phase >= 10 && phase < 16) ? 0 : 11;
            case ($urandom_range(0, 19)) inside
                [0:5]:   mode = fsvtm_pkg::MODE_EXACT;
                [6:11]:  mode = fsvtm_pkg::MODE_RANGE;
                [12:17]: mode = fsvtm_pkg::MODE_MASK;
                default: mode = 2'd3;
            endcase
            foreach (w[i]) w[i] = pick_value();
            // Mostly a proper range, but leave some empty ones.
            if (mode == fsvtm_pkg::MODE_RANGE && w[0] > w[1] && $urandom_range(0, 4) != 0) begin
                tmp  = w[0];
                w[0] = w[1];
                w[1] = tmp;
            end
            // Sparse masks make the lowest-position rule visible more often.
            if (mode == fsvtm_pkg::MODE_MASK && $urandom_range(0, 2) == 0)
                w[1] = w[1] & rand64();
            tmp      = rand64();
            mode_val = ($urandom_range(0, 3) == 0) ? {tmp[63:2], mode} : 64'(mode);
            k        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            tmp      = rand64();
            wc_val   = ($urandom_range(0, 3) == 0) ? {tmp[63:3], 3'(k)} : 64'(k);
            set_cfg(mode_val, wc_val, w[0], w[1], w[2], w[3]);

            for (int n = 0; n < 50; n++) begin
                if (sb.mode_q == fsvtm_pkg::MODE_MASK) begin
                    // Mostly the expected value with a few flipped or unknown bits.
                    case ($urandom_range(0, 4))
                        0, 1:    bits = sb.words[0];
                        2:       bits = sb.words[0] ^ one_hot();
                        3:       bits = sb.words[0] ^ (rand64() & rand64());
                        default: bits = rand64();
                    endcase
                    case ($urandom_range(0, 4))
                        0, 1:    unk = '0;
                        2:       unk = one_hot();
                        3:       unk = rand64() & rand64() & rand64();
                        default: unk = rand64();
                    endcase
                end else begin
                    // Well-formed samples near table words and range ends dominate.
                    case ($urandom_range(0, 5))
                        0, 1:    bits = sb.words[$urandom_range(0, fsvtm_pkg::NUM_WORDS - 1)];
                        2:       bits = sb.words[0] +
                                        fsvtm_pkg::t_value'($urandom_range(0, 2)) - 1'b1;
                        3:       bits = sb.words[1] +
                                        fsvtm_pkg::t_value'($urandom_range(0, 2)) - 1'b1;
                        default: bits = pick_value();
                    endcase
                    case ($urandom_range(0, 9))
                        0:       unk = rand64();
                        1:       unk = one_hot();
                        default: unk = '0;
                    endcase
                end
                drive_req(mk(bits, unk, $urandom_range(0, 9) != 0, 2'($urandom_range(0, 3))));
            end
        end

        drain();
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### four_state_value_trigger_match.f
hdl/fsvtm_pkg.sv
hdl/four_state_value_trigger_match.sv
dv/tb_four_state_value_trigger_match.sv
